FILE: rtl/qpst_pkg.sv
// ============================================================================
// qpst_pkg: shared types and constants of the quadrature position tracker
// Register map, item codes, field widths and the control word of the shared
// multiply/divide unit.
// ============================================================================
package qpst_pkg;

    // Default widths of the sampled counter and of the position accumulator
    localparam int COUNTER_BITS_DEF  = 16;
    localparam int POSITION_BITS_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register widths
    localparam int CPR_W   = 16;
    localparam int APC_W   = 27;
    localparam int SPC_W   = 32;
    localparam int COEFF_W = 17;
    localparam int DBAND_W = 32;
    localparam int RPMF_W  = 24;

    // Item and result field widths
    localparam int OP_W      = 2;
    localparam int POS_OUT_W = 32;
    localparam int ANGLE_W   = 19;
    localparam int SPEED_W   = 37;
    localparam int RPM_W     = 41;
    localparam int TURN_W    = 32;

    // Shared unit: 64-bit accumulator, 32-bit multiplier, 4-bit digit per step
    localparam int ACC_W       = 64;
    localparam int MUL_B_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int REM_W       = CPR_W + 1;
    localparam int FRAC_W      = 16;
    localparam int TERM_W      = ACC_W - FRAC_W;
    localparam int ANGLE_SHIFT = 8;

    // Configuration reset values
    localparam logic [CPR_W-1:0]   CPR_RST   = 16'd4000;
    localparam logic [APC_W-1:0]   APC_RST   = 27'd26353;
    localparam logic [SPC_W-1:0]   SPC_RST   = 32'd2058874;
    localparam logic [COEFF_W-1:0] COEFF_RST = 17'd3860;
    localparam logic [DBAND_W-1:0] DBAND_RST = 32'd32768;
    localparam logic [RPMF_W-1:0]  RPMF_RST  = 24'd625828;

    // Saturation limits
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = {ANGLE_W{1'b1}};
    localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic [RPM_W-1:0]   RPM_MAX   = {1'b0, {(RPM_W-1){1'b1}}};
    localparam logic [RPM_W-1:0]   RPM_MIN   = {1'b1, {(RPM_W-1){1'b0}}};

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNTS_PER_REV  = 3'd0,
        REG_ANGLE_PER_COUNT = 3'd1,
        REG_SPEED_PER_COUNT = 3'd2,
        REG_FILTER_COEFF    = 3'd3,
        REG_SPEED_DEADBAND  = 3'd4,
        REG_RPM_FACTOR      = 3'd5
    } t_reg_idx;

    // Item codes
    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_INDEX  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // Configuration register set
    typedef struct packed {
        logic [CPR_W-1:0]   counts_per_rev;
        logic [APC_W-1:0]   angle_per_count;
        logic [SPC_W-1:0]   speed_per_count;
        logic [COEFF_W-1:0] filter_coeff;
        logic [DBAND_W-1:0] speed_deadband;
        logic [RPMF_W-1:0]  rpm_factor;
    } t_cfg;

    // Control word of the shared unit
    typedef struct packed {
        logic load;
        logic mac_step;
        logic div_step;
    } t_alu_ctrl;

endpackage

FILE: rtl/qpst_cfg.sv
// ============================================================================
// qpst_cfg: configuration registers
// Six scaling registers written over a valid/ready port, one transfer per
// write, indexes outside the map ignored.
// ============================================================================
module qpst_cfg
    import qpst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Always able to take a write
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.counts_per_rev  <= CPR_RST;
            r_cfg.angle_per_count <= APC_RST;
            r_cfg.speed_per_count <= SPC_RST;
            r_cfg.filter_coeff    <= COEFF_RST;
            r_cfg.speed_deadband  <= DBAND_RST;
            r_cfg.rpm_factor      <= RPMF_RST;
        end else if (i_valid) begin
            case (i_index)
                REG_COUNTS_PER_REV:  r_cfg.counts_per_rev  <= CPR_W'(i_data);
                REG_ANGLE_PER_COUNT: r_cfg.angle_per_count <= APC_W'(i_data);
                REG_SPEED_PER_COUNT: r_cfg.speed_per_count <= SPC_W'(i_data);
                REG_FILTER_COEFF:    r_cfg.filter_coeff    <= COEFF_W'(i_data);
                REG_SPEED_DEADBAND:  r_cfg.speed_deadband  <= DBAND_W'(i_data);
                REG_RPM_FACTOR:      r_cfg.rpm_factor      <= RPMF_W'(i_data);
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/qpst_alu.sv
// ============================================================================
// qpst_alu: shared multiply / remainder unit
// Radix-16 shift-and-add multiplier that runs until the multiplier is
// exhausted, and a restoring remainder step, one dividend bit per cycle.
// ============================================================================
module qpst_alu
    import qpst_pkg::*;
(
    input  logic               i_clk,
    input  t_alu_ctrl          i_ctrl,
    input  logic [ACC_W-1:0]   i_load_a,
    input  logic [MUL_B_W-1:0] i_load_b,
    input  logic [CPR_W-1:0]   i_divisor,
    output logic [ACC_W-1:0]   o_acc,
    output logic               o_b_zero
);

    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [ACC_W-1:0]   w_pp;
    logic [REM_W-1:0]   w_trial;
    logic               w_fits;

    // Partial product of one digit and the trial remainder
    always_comb begin
        w_pp    = r_a * ACC_W'(r_b[DIGIT_W-1:0]);
        w_trial = {r_acc[CPR_W-1:0], r_a[ACC_W-1]};
        w_fits  = (w_trial >= {1'b0, i_divisor});
    end

    // Load operands, accumulate a digit, or take a remainder step
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_acc <= '0;
            r_a   <= i_load_a;
            r_b   <= i_load_b;
        end else if (i_ctrl.mac_step) begin
            r_acc <= r_acc + w_pp;
            r_a   <= r_a << DIGIT_W;
            r_b   <= r_b >> DIGIT_W;
        end else if (i_ctrl.div_step) begin
            r_acc <= ACC_W'(w_fits ? (w_trial - {1'b0, i_divisor}) : w_trial);
            r_a   <= r_a << 1;
        end
    end

    assign o_acc    = r_acc;
    assign o_b_zero = (r_b == '0);

endmodule

FILE: rtl/quadrature_position_speed_tracker.sv
// ============================================================================
// quadrature_position_speed_tracker: encoder position and speed estimator
// Each item is a counter sample, an index pulse or a clear of the position
// state, and each gives one result: position, mechanical angle, filtered
// speed in rad/s and rpm (zero under the deadband, saturated), turn count and
// direction. The block takes one item at a time; input stall stays high until
// the item is finished. The multiplies and the remainder run on one shared
// unit: a remainder step of one bit per cycle and a radix-16 multiplier that
// stops when its multiplier runs out. A sample item computes the position
// modulo counts per revolution, then runs four multiplies (angle, raw speed,
// filter, rpm); with counts per revolution zero the remainder and the angle
// multiply are skipped and the angle is zero. An index, clear or unused item
// runs the rpm multiply only. The next item is taken only once the result is
// in the output register, where it waits while the next item runs.
// ============================================================================
module quadrature_position_speed_tracker
    import qpst_pkg::*;
#(
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // item channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_op,
    input  logic [COUNTER_BITS-1:0]  i_timer_value,
    input  logic                     i_count_down,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [POS_OUT_W-1:0] o_position_counts,
    output logic [ANGLE_W-1:0]       o_mech_angle,
    output logic signed [SPEED_W-1:0] o_speed_rad_s,
    output logic signed [RPM_W-1:0]  o_speed_rpm,
    output logic signed [TURN_W-1:0] o_turn_count,
    output logic                     o_moving_backward
);

    localparam int DELTA_W = COUNTER_BITS + 1;
    localparam int EXT_W   = (DELTA_W > POSITION_BITS) ? DELTA_W : POSITION_BITS;
    localparam int CNT_W   = $clog2(POSITION_BITS);
    localparam int ALIGN   = ACC_W - POSITION_BITS;
    localparam int SUM_W   = TERM_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_POS,
        S_DIV_LD,
        S_DIV,
        S_MOD,
        S_ANGLE,
        S_SPD_LD,
        S_SPEED,
        S_DIFF,
        S_FILT,
        S_FUPD,
        S_RPM_LD,
        S_RPM,
        S_DONE
    } t_state;

    t_cfg w_cfg;

    // sequencer and tracking state
    t_state                   r_state;
    logic [COUNTER_BITS-1:0]  r_tv;
    logic                     r_down;
    logic [COUNTER_BITS-1:0]  r_last;
    logic [DELTA_W-1:0]       r_delta;
    logic [POSITION_BITS-1:0] r_pos;
    logic [CNT_W-1:0]         r_cnt;
    logic [ANGLE_W-1:0]       r_angle;
    logic [SPEED_W-1:0]       r_sraw;
    logic [SPEED_W-1:0]       r_filt;
    logic [SPEED_W-1:0]       r_absf;
    logic [TERM_W-1:0]        r_term;
    logic                     r_sign;
    logic [TURN_W-1:0]        r_turns;
    logic                     r_dir;

    // result register
    logic                     r_out_valid;
    logic [POS_OUT_W-1:0]     r_out_pos;
    logic [ANGLE_W-1:0]       r_out_angle;
    logic [SPEED_W-1:0]       r_out_rad;
    logic [RPM_W-1:0]         r_out_rpm;
    logic [TURN_W-1:0]        r_out_turns;
    logic                     r_out_dir;

    // shared unit
    t_alu_ctrl                w_ctrl;
    logic [ACC_W-1:0]         w_load_a;
    logic [MUL_B_W-1:0]       w_load_b;
    logic [ACC_W-1:0]         w_acc;
    logic                     w_b_zero;

    // datapath around the unit
    logic                     w_in_xfer;
    logic [DELTA_W-1:0]       w_raw;
    logic                     w_half_code;
    logic [DELTA_W-1:0]       n_delta;
    logic [EXT_W-1:0]         w_delta_ext;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] w_pos_mag;
    logic [CPR_W-1:0]         w_rem;
    logic [CPR_W-1:0]         w_mod;
    logic [ANGLE_W-1:0]       n_angle;
    logic [DELTA_W-1:0]       w_delta_mag;
    logic                     w_over_pos;
    logic                     w_over_neg;
    logic [SPEED_W-1:0]       n_sraw;
    logic [SPEED_W:0]         w_diff_p;
    logic [SPEED_W:0]         w_diff_n;
    logic                     w_diff_neg;
    logic [SPEED_W-1:0]       w_diff_mag;
    logic [ACC_W-1:0]         w_sprod;
    logic [TERM_W-1:0]        w_term;
    logic [SUM_W-1:0]         w_fsum;
    logic [SUM_W-SPEED_W:0]   w_fsum_top;
    logic [SPEED_W-1:0]       n_filt;
    logic [SPEED_W-1:0]       w_f_mag;
    logic [TERM_W-RPM_W:0]    w_rpm_top;
    logic [RPM_W-1:0]         n_rpm;
    logic                     w_dead;

    qpst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    qpst_alu u_alu (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_load_a  (w_load_a),
        .i_load_b  (w_load_b),
        .i_divisor (w_cfg.counts_per_rev),
        .o_acc     (w_acc),
        .o_b_zero  (w_b_zero)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // Wrap the counter difference into -half..+half
    always_comb begin
        w_raw       = {1'b0, r_tv} - {1'b0, r_last};
        w_half_code = w_raw[COUNTER_BITS-1] && (w_raw[COUNTER_BITS-2:0] == '0);
        n_delta     = w_half_code ? w_raw
                                  : {w_raw[COUNTER_BITS-1], w_raw[COUNTER_BITS-1:0]};
        w_delta_ext = EXT_W'($signed(r_delta));
        n_pos       = r_pos + w_delta_ext[POSITION_BITS-1:0];
        w_pos_mag   = r_pos[POSITION_BITS-1] ? (~r_pos) + POSITION_BITS'(1) : r_pos;
        w_delta_mag = r_delta[DELTA_W-1] ? (~r_delta) + DELTA_W'(1) : r_delta;
    end

    // Floor modulo from the unsigned remainder, then angle saturation
    always_comb begin
        w_rem   = w_acc[CPR_W-1:0];
        w_mod   = (r_pos[POSITION_BITS-1] && (w_rem != '0))
                  ? w_cfg.counts_per_rev - w_rem : w_rem;
        n_angle = (|w_acc[ACC_W-1:ANGLE_W+ANGLE_SHIFT])
                  ? ANGLE_MAX : w_acc[ANGLE_W+ANGLE_SHIFT-1:ANGLE_SHIFT];
    end

    // Raw speed: apply sign and saturate to 37 bits
    always_comb begin
        w_over_pos = |w_acc[ACC_W-1:SPEED_W-1];
        w_over_neg = (|w_acc[ACC_W-1:SPEED_W])
                     || (w_acc[SPEED_W-1] && (|w_acc[SPEED_W-2:0]));
        if (r_sign) begin
            n_sraw = w_over_neg ? SPEED_MIN : (~w_acc[SPEED_W-1:0]) + SPEED_W'(1);
        end else begin
            n_sraw = w_over_pos ? SPEED_MAX : w_acc[SPEED_W-1:0];
        end
    end

    // Filter error magnitude, both subtractions side by side
    always_comb begin
        w_diff_p   = {r_sraw[SPEED_W-1], r_sraw} - {r_filt[SPEED_W-1], r_filt};
        w_diff_n   = {r_filt[SPEED_W-1], r_filt} - {r_sraw[SPEED_W-1], r_sraw};
        w_diff_neg = w_diff_p[SPEED_W];
        w_diff_mag = w_diff_neg ? w_diff_n[SPEED_W-1:0] : w_diff_p[SPEED_W-1:0];
    end

    // Signed product, floor shift by 16
    always_comb begin
        w_sprod = r_sign ? (~w_acc) + ACC_W'(1) : w_acc;
        w_term  = w_sprod[ACC_W-1:FRAC_W];
    end

    // Filter update and rpm saturation
    always_comb begin
        w_fsum     = SUM_W'($signed(r_filt)) + SUM_W'($signed(r_term));
        w_fsum_top = w_fsum[SUM_W-1:SPEED_W-1];
        if ((&w_fsum_top) || !(|w_fsum_top)) begin
            n_filt = w_fsum[SPEED_W-1:0];
        end else begin
            n_filt = w_fsum[SUM_W-1] ? SPEED_MIN : SPEED_MAX;
        end
        w_f_mag   = r_filt[SPEED_W-1] ? (~r_filt) + SPEED_W'(1) : r_filt;
        w_rpm_top = r_term[TERM_W-1:RPM_W-1];
        if ((&w_rpm_top) || !(|w_rpm_top)) begin
            n_rpm = r_term[RPM_W-1:0];
        end else begin
            n_rpm = r_term[TERM_W-1] ? RPM_MIN : RPM_MAX;
        end
        w_dead = (r_absf < SPEED_W'(w_cfg.speed_deadband));
    end

    // Drive the shared unit from the sequencer state
    always_comb begin
        w_ctrl   = '0;
        w_load_a = '0;
        w_load_b = '0;
        case (r_state)
            S_DIV_LD: begin
                if (w_cfg.counts_per_rev != '0) begin
                    w_ctrl.load = 1'b1;
                    w_load_a    = ACC_W'(w_pos_mag) << ALIGN;
                end
            end
            S_DIV: begin
                w_ctrl.div_step = 1'b1;
            end
            S_MOD: begin
                w_ctrl.load = 1'b1;
                w_load_a    = ACC_W'(w_cfg.angle_per_count);
                w_load_b    = MUL_B_W'(w_mod);
            end
            S_SPD_LD: begin
                w_ctrl.load = 1'b1;
                w_load_a    = ACC_W'(w_cfg.speed_per_count);
                w_load_b    = MUL_B_W'(w_delta_mag);
            end
            S_DIFF: begin
                w_ctrl.load = 1'b1;
                w_load_a    = ACC_W'(w_diff_mag);
                w_load_b    = MUL_B_W'(w_cfg.filter_coeff);
            end
            S_RPM_LD: begin
                w_ctrl.load = 1'b1;
                w_load_a    = ACC_W'(w_f_mag);
                w_load_b    = MUL_B_W'(w_cfg.rpm_factor);
            end
            S_ANGLE, S_SPEED, S_FILT, S_RPM: begin
                w_ctrl.mac_step = !w_b_zero;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, tracking state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_pos       <= '0;
            r_filt      <= '0;
            r_angle     <= '0;
            r_turns     <= '0;
            r_dir       <= 1'b0;
        end else begin
            // drop the result once it is taken, unless a new one replaces it
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_tv   <= i_timer_value;
                        r_down <= i_count_down;
                        case (i_op)
                            OP_SAMPLE: begin
                                r_state <= S_DELTA;
                            end
                            OP_INDEX: begin
                                r_turns <= r_dir ? r_turns - TURN_W'(1)
                                                 : r_turns + TURN_W'(1);
                                r_state <= S_RPM_LD;
                            end
                            OP_CLEAR: begin
                                r_pos   <= '0;
                                r_last  <= '0;
                                r_filt  <= '0;
                                r_angle <= '0;
                                r_turns <= '0;
                                r_state <= S_RPM_LD;
                            end
                            default: begin
                                r_state <= S_RPM_LD;
                            end
                        endcase
                    end
                end
                S_DELTA: begin
                    r_delta <= n_delta;
                    r_last  <= r_tv;
                    r_dir   <= r_down;
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_pos   <= n_pos;
                    r_state <= S_DIV_LD;
                end
                S_DIV_LD: begin
                    r_cnt <= '0;
                    if (w_cfg.counts_per_rev == '0) begin
                        r_angle <= '0;
                        r_state <= S_SPD_LD;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(POSITION_BITS - 1)) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_state <= S_ANGLE;
                end
                S_ANGLE: begin
                    if (w_b_zero) begin
                        r_angle <= n_angle;
                        r_state <= S_SPD_LD;
                    end
                end
                S_SPD_LD: begin
                    r_sign  <= r_delta[DELTA_W-1];
                    r_state <= S_SPEED;
                end
                S_SPEED: begin
                    if (w_b_zero) begin
                        r_sraw  <= n_sraw;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_sign  <= w_diff_neg;
                    r_state <= S_FILT;
                end
                S_FILT: begin
                    if (w_b_zero) begin
                        r_term  <= w_term;
                        r_state <= S_FUPD;
                    end
                end
                S_FUPD: begin
                    r_filt  <= n_filt;
                    r_state <= S_RPM_LD;
                end
                S_RPM_LD: begin
                    r_sign  <= r_filt[SPEED_W-1];
                    r_absf  <= w_f_mag;
                    r_state <= S_RPM;
                end
                S_RPM: begin
                    if (w_b_zero) begin
                        r_term  <= w_term;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the previous result has been taken
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= POS_OUT_W'(r_pos);
                        r_out_angle <= r_angle;
                        r_out_rad   <= w_dead ? '0 : r_filt;
                        r_out_rpm   <= w_dead ? '0 : n_rpm;
                        r_out_turns <= r_turns;
                        r_out_dir   <= r_dir;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_position_counts = r_out_pos;
    assign o_mech_angle      = r_out_angle;
    assign o_speed_rad_s     = r_out_rad;
    assign o_speed_rpm       = r_out_rpm;
    assign o_turn_count      = r_out_turns;
    assign o_moving_backward = r_out_dir;

    // A new result only ever comes out of the final state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the final state");

    // A clear item empties position and turn count
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_op == OP_CLEAR)) |=> (r_pos == '0) && (r_turns == '0))
        else $error("clear item left position state behind");

    // Remainder pass never runs past the dividend width
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CNT_W'(POSITION_BITS - 1)))
        else $error("remainder counter overran");

    // The speed multiply is left only with its multiplier exhausted
    a_speed_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIFF) |-> $past(w_b_zero))
        else $error("speed product taken before the multiply finished");

endmodule
